@@ hdl/dms_pkg.sv @@
// Shared types and constants for the DNA minimizer stream unit.
package dms_pkg;

  localparam int unsigned WinDepth = 16;

  localparam logic [63:0] MixMulA = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixMulB = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] CfgKmerLen   = 2'd0;
  localparam logic [1:0] CfgWindowLen = 2'd1;

  localparam logic [1:0] BaseA = 2'd0;
  localparam logic [1:0] BaseC = 2'd1;
  localparam logic [1:0] BaseG = 2'd2;
  localparam logic [1:0] BaseT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_CHECK = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  // Control shared by every window cell
  typedef struct packed {
    logic       shift;
    logic       clr;
    logic [4:0] win;
  } cell_ctl_t;

endpackage

@@ hdl/dms_minimizer_stream_unit.sv @@
// Top level: base decode, k-mer registers, hash sequencing and the window chain.
//
// Each base is accepted in the idle state; a base that leaves no k-mer to hash
// is then done. Otherwise the hash runs its two 64-bit products as three
// 32x32 partial products each on one shared multiplier, then the window chain
// shifts and the window minimum is read. A base that yields a result then
// enters a wait state, in which the result is loaded into the output
// register; while an earlier result still waits there the block holds until
// it is taken. No clearing pass follows reset.
module dna_minimizer_stream_unit
  import dms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] base_char
  input  logic        s_tuser,   // [0] seq_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] minimizer_hash
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  state_t      state;
  logic [5:0]  kmer_len;
  logic [4:0]  window_len;
  logic [63:0] fwd;
  logic [63:0] rev;
  logic [5:0]  valid_run;
  logic [63:0] last_emitted;
  logic        emit_ok;

  logic [5:0]  k_eff;
  logic [4:0]  w_eff;
  logic        acc;
  logic        is_base;
  logic [1:0]  code;
  logic [63:0] fwd_base;
  logic [63:0] rev_base;
  logic [5:0]  vr_base;
  logic [63:0] mask;
  logic [63:0] fwd_next;
  logic [63:0] rev_next;
  logic [5:0]  limit;
  logic [5:0]  vr_next;
  logic [6:0]  rev_shift;
  logic        mix_done;
  logic [63:0] mix_out;
  logic        out_free;

  cell_ctl_t   ctl;
  logic [WinDepth-1:0]       cvalid;
  logic [63:0]               chash [WinDepth];
  logic [63:0]               cfront [WinDepth+1];

  assign acc      = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;

  // Clamp registers to their working ranges
  always_comb begin
    if (kmer_len == 6'd0) begin
      k_eff = 6'd1;
    end else if (kmer_len > 6'd32) begin
      k_eff = 6'd32;
    end else begin
      k_eff = kmer_len;
    end
    if (window_len == 5'd0) begin
      w_eff = 5'd1;
    end else if (window_len > 5'd16) begin
      w_eff = 5'd16;
    end else begin
      w_eff = window_len;
    end
  end

  // Decode the character
  always_comb begin
    is_base = 1'b1;
    unique case (s_tdata)
      8'h41, 8'h61: code = BaseA;
      8'h43, 8'h63: code = BaseC;
      8'h47, 8'h67: code = BaseG;
      8'h54, 8'h74: code = BaseT;
      default: begin
        code    = BaseA;
        is_base = 1'b0;
      end
    endcase
  end

  // Next k-mers and run length
  always_comb begin
    fwd_base  = s_tuser ? 64'd0 : fwd;
    rev_base  = s_tuser ? 64'd0 : rev;
    vr_base   = s_tuser ? 6'd0 : valid_run;
    mask      = (k_eff == 6'd32) ? '1 : ((64'd1 << {k_eff, 1'b0}) - 64'd1);
    fwd_next  = ((fwd_base << 2) | {62'd0, code}) & mask;
    rev_shift = {k_eff, 1'b0} - 7'd2;
    rev_next  = (rev_base >> 2) | ({62'd0, BaseT - code} << rev_shift);
    limit     = k_eff + {1'b0, w_eff} - 6'd1;
    vr_next   = (vr_base < limit) ? vr_base + 6'd1 : limit;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len   <= 6'd21;
      window_len <= 5'd11;
    end else if (cfg_we) begin
      if (cfg_index == CfgKmerLen) begin
        kmer_len <= cfg_data;
      end else if (cfg_index == CfgWindowLen) begin
        window_len <= cfg_data[4:0];
      end
    end
  end

  // Sequence control, k-mer state and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fwd          <= '0;
      rev          <= '0;
      valid_run    <= '0;
      last_emitted <= '1;
      m_tvalid     <= 1'b0;
      emit_ok      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (s_tuser) begin
              last_emitted <= '1;
            end
            if (!is_base) begin
              fwd       <= '0;
              rev       <= '0;
              valid_run <= '0;
            end else begin
              fwd       <= fwd_next;
              rev       <= rev_next;
              valid_run <= vr_next;
              emit_ok   <= (vr_next >= limit);
              if (vr_next >= k_eff) begin
                state <= S_HASH;
              end
            end
          end
        end
        S_HASH: begin
          if (mix_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (emit_ok && (cfront[WinDepth] != last_emitted)) begin
            state <= S_WAIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            m_tdata      <= cfront[WinDepth];
            last_emitted <= cfront[WinDepth];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dms_mixer u_mixer (
    .clk   (clk),
    .rst   (rst),
    .start (acc && is_base && (vr_next >= k_eff)),
    .din   ((fwd_next < rev_next) ? fwd_next : rev_next),
    .done  (mix_done),
    .dout  (mix_out)
  );

  // Window chain: slot i holds the entry of age i; the front runs from the
  // newest slot towards the oldest, so the oldest valid entry comes out last
  assign ctl.shift = (state == S_HASH) && mix_done;
  assign ctl.clr   = acc && (s_tuser || !is_base);
  assign ctl.win   = w_eff;
  assign cfront[0] = mix_out;

  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    dms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .age        (4'(i)),
      .new_hash   (mix_out),
      .prev_valid ((i == 0) ? 1'b1 : cvalid[(i == 0) ? 0 : i - 1]),
      .prev_hash  ((i == 0) ? mix_out : chash[(i == 0) ? 0 : i - 1]),
      .front_in   (cfront[i]),
      .valid      (cvalid[i]),
      .hash       (chash[i]),
      .front_out  (cfront[i + 1])
    );
  end

  // The newest slot is filled whenever the next older one is
  a_chain_prefix: assert property (@(posedge clk) disable iff (rst)
    cvalid[1] |-> cvalid[0])
    else $error("window slot valid without newest slot");

  // The hash finishes only while the sequencer waits for it
  a_mix_state: assert property (@(posedge clk) disable iff (rst)
    mix_done |-> (state == S_HASH))
    else $error("hash done outside hash state");

  // Hold a waiting output beat until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output beat changed while waiting");

endmodule

@@ hdl/dms_mixer.sv @@
// 64-bit xor-shift/multiply hash, three partial products per product on one 32x32 multiplier.
module dms_mixer
  import dms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);

  logic [63:0] x;
  logic [63:0] acc;
  logic        busy;
  logic        pass;
  logic [1:0]  part;
  logic [63:0] mconst;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] acc_next;

  assign mconst = pass ? MixMulB : MixMulA;

  // Pick the partial product for this step
  always_comb begin
    unique case (part)
      2'd0:    begin op_a = x[31:0];  op_b = mconst[31:0];  end
      2'd1:    begin op_a = x[63:32]; op_b = mconst[31:0];  end
      default: begin op_a = x[31:0];  op_b = mconst[63:32]; end
    endcase
  end

  assign prod = {32'd0, op_a} * {32'd0, op_b};

  always_comb begin
    if (part == 2'd0) begin
      acc_next = prod;
    end else begin
      acc_next = acc + {prod[31:0], 32'd0};
    end
  end

  // Step the multiply sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pass <= 1'b0;
      part <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pass <= 1'b0;
        part <= 2'd0;
      end else if (busy) begin
        if (part == 2'd2) begin
          part <= 2'd0;
          pass <= 1'b1;
          if (pass) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          part <= part + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= din ^ (din >> 33);
    end else if (busy) begin
      acc <= acc_next;
      if (part == 2'd2) begin
        x <= acc_next ^ (acc_next >> 33);
      end
    end
  end

  assign dout = x;

endmodule

@@ hdl/dms_cell.sv @@
// One window slot: holds the entry of one age and passes it to the next slot.
module dms_cell
  import dms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  logic [3:0]  age,
  input  logic [63:0] new_hash,
  input  logic        prev_valid,
  input  logic [63:0] prev_hash,
  input  logic [63:0] front_in,
  output logic        valid,
  output logic [63:0] hash,
  output logic [63:0] front_out
);

  // Oldest valid entry seen so far along the chain
  assign front_out = valid ? hash : front_in;

  // Keep the shifted entry while young enough and not above the new hash
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= prev_valid && ({1'b0, age} < ctl.win) && (prev_hash <= new_hash);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hash <= prev_hash;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the DNA minimizer stream unit.
`timescale 1ns / 1ps

module tb_top;
  import dms_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h41;   // [7:0] base_char
  logic        s_tuser = 1'b0;    // [0] seq_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [63:0] minimizer_hash
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CfgKmerLen;
  logic [5:0]  cfg_data = '0;

  dna_minimizer_stream_unit uut (.*);

  always #6 clk = ~clk;

  // Predictor state
  int unsigned  kmer_cfg, win_cfg;
  logic [63:0]  fwd_kmer, rev_kmer, last_hash;
  int unsigned  run_len, win_fill;
  logic [63:0]  win_hash [WinDepth];
  int unsigned  win_age [WinDepth];
  logic [63:0]  hash_q [$];

  int unsigned  n_fail = 0;
  bit           quiet_tail = 0;
  int           send_gap = 0;

  function automatic logic [63:0] mixer(logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * MixMulA;
    v = v ^ (v >> 33);
    v = v * MixMulB;
    v = v ^ (v >> 33);
    return v;
  endfunction

  function automatic void clear_run();
    fwd_kmer = '0; rev_kmer = '0; run_len = 0; win_fill = 0;
  endfunction

  // Advance the predictor by one accepted beat
  function automatic void predict_base(logic [7:0] ch, logic start);
    int unsigned k, w, lim, j, code;
    logic [63:0] msk, canon, h;
    k = (kmer_cfg < 1) ? 1 : (kmer_cfg > 32 ? 32 : kmer_cfg);
    w = (win_cfg < 1) ? 1 : (win_cfg > WinDepth ? WinDepth : win_cfg);
    if (start) begin
      clear_run();
      last_hash = '1;
    end
    case (ch)
      "A", "a": code = BaseA;
      "C", "c": code = BaseC;
      "G", "g": code = BaseG;
      "T", "t": code = BaseT;
      default: code = 4;
    endcase
    if (code == 4) begin
      clear_run();
      return;
    end
    msk = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 1);
    fwd_kmer = ((fwd_kmer << 2) | code) & msk;
    rev_kmer = (rev_kmer >> 2) | (64'(3 - code) << (2 * (k - 1)));
    lim = k + w - 1;
    run_len = (run_len < lim) ? run_len + 1 : lim;
    if (run_len < k) return;
    canon = (fwd_kmer < rev_kmer) ? fwd_kmer : rev_kmer;
    h = mixer(canon);
    for (int i = 0; i < win_fill; i++) win_age[i]++;
    j = 0;
    while (j < win_fill && win_age[j] >= w) j++;
    if (j > 0) begin
      for (int i = j; i < win_fill; i++) begin
        win_hash[i - j] = win_hash[i];
        win_age[i - j] = win_age[i];
      end
      win_fill -= j;
    end
    while (win_fill > 0 && win_hash[win_fill - 1] > h) win_fill--;
    if (win_fill >= WinDepth) win_fill = WinDepth - 1;
    win_hash[win_fill] = h;
    win_age[win_fill] = 0;
    win_fill++;
    if (run_len >= lim && win_hash[0] != last_hash) begin
      last_hash = win_hash[0];
      hash_q.insert(hash_q.size(), win_hash[0]);
    end
  endfunction

  // Check accepted results against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (hash_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected hash %h", m_tdata);
      end else begin
        logic [63:0] exp_h;
        exp_h = hash_q.pop_front();
        if (exp_h !== m_tdata) begin
          n_fail++;
          if (n_fail <= 10) $display("hash mismatch: exp %h got %h", exp_h, m_tdata);
        end
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (quiet_tail) m_tready <= 1'b1;
      else if (m_tready && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 10);
        repeat (stall - 1) @(negedge clk);
        m_tready <= 1'b1;
      end else m_tready <= 1'b1;
    end
  end

  // Send one beat; the predictor runs at acceptance
  task automatic send_beat(logic [7:0] ch, logic start);
    if (!quiet_tail && send_gap == 0 && $urandom_range(0, 9) == 0)
      send_gap = $urandom_range(1, 10);
    while (send_gap > 0) begin
      send_gap--;
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    predict_base(ch, start);
    @(negedge clk);
  endtask

  // Wait for the block to drain, then idle past any hash in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    while (hash_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgKmerLen) kmer_cfg = val;
    else if (idx == CfgWindowLen) win_cfg = val[4:0];
  endtask

  function automatic logic [7:0] rand_base();
    logic [7:0] s;
    case ($urandom_range(0, 3))
      0: s = "A";
      1: s = "C";
      2: s = "G";
      default: s = "T";
    endcase
    return $urandom_range(0, 1) ? s : (s | 8'h20);
  endfunction

  typedef struct { logic [7:0] ch; logic start; } beat_t;

  // Directed table: every base in both cases, breakers, extremes of the byte
  beat_t dir_tab [] = '{
    '{"A", 1'b1}, '{"C", 1'b0}, '{"G", 1'b0}, '{"T", 1'b0}, '{"a", 1'b0},
    '{"c", 1'b0}, '{"g", 1'b0}, '{"t", 1'b0}, '{"N", 1'b0}, '{"G", 1'b0},
    '{"G", 1'b0}, '{8'h00, 1'b0}, '{"T", 1'b0}, '{"T", 1'b0}, '{8'hff, 1'b0},
    '{"C", 1'b1}, '{"A", 1'b0}, '{"A", 1'b0}, '{"A", 1'b0}, '{8'hc1, 1'b0},
    '{"t", 1'b0}, '{"g", 1'b1}, '{"g", 1'b0}, '{"g", 1'b0}
  };

  // Register settings per phase: extremes and out-of-range values included
  int unsigned ph_k [] = '{1, 32, 0, 63, 5, 15, 3, 21, 9, 40};
  int unsigned ph_w [] = '{1, 16, 0, 31, 4, 7, 2, 11, 16, 20};

  initial begin
    kmer_cfg = 21; win_cfg = 11;
    clear_run();
    last_hash = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short k and window so the table produces hashes
    write_reg(CfgKmerLen, 6'd2);
    write_reg(CfgWindowLen, 6'd2);
    write_reg(2'd3, 6'd7);
    foreach (dir_tab[i]) send_beat(dir_tab[i].ch, dir_tab[i].start);
    drain();

    foreach (ph_k[p]) begin
      write_reg(CfgKmerLen, 6'(ph_k[p]));
      write_reg(CfgWindowLen, 6'(ph_w[p]));
      if (p == ph_k.size() - 1) quiet_tail = 1;
      for (int n = 0; n < 195; n++) begin
        logic [7:0] ch;
        logic st;
        st = (n == 0) || ($urandom_range(0, 99) == 0);
        case ($urandom_range(0, 39))
          0: ch = 8'($urandom);
          1: ch = "N";
          default: ch = rand_base();
        endcase
        send_beat(ch, st);
      end
      drain();
    end

    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("status: fail");
    $finish;
  end
endmodule
